// ===== rtl/arqfr_pkg.sv =====
package arqfr_pkg;

   // Size of the sequence space and of the mark store.
   localparam int SEQ_COUNT = 64;
   localparam int SEQ_W = $clog2(SEQ_COUNT);
   localparam int EXP_W = $clog2(SEQ_COUNT + 1);

   // Byte that escapes the following byte in the stuffed stream.
   localparam logic [7:0] ESCAPE_BYTE = 8'h2F;

   // Per-frame marks held in the mark store.
   localparam logic [1:0] MARK_UNKNOWN = 2'd0;
   localparam logic [1:0] MARK_GOOD    = 2'd1;
   localparam logic [1:0] MARK_BAD     = 2'd2;

   // Reply kinds.
   localparam logic REPLY_ACK  = 1'b0;
   localparam logic REPLY_NACK = 1'b1;

   // Command queue between the byte front end and the window back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One end-of-frame command: the frame's number and its checksum verdict.
   typedef struct packed {
      logic [5:0] seq;
      logic       good;
   } frame_cmd_type;

   // Push request from the front end into the queue.
   typedef struct packed {
      logic          push;
      frame_cmd_type cmd;
   } cmd_push_type;

   // Queue status seen by both neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_NACK,
      ST_FLUSH,
      ST_AHEAD
   } back_state_type;

endpackage

// ===== rtl/arqfr_req_if.sv =====
interface arqfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_last;
   logic [5:0] frame_seq;
   logic [7:0] trailer_sum;

   modport source (output valid, output data_byte, output frame_last,
                   output frame_seq, output trailer_sum, input ready);
   modport sink   (input valid, input data_byte, input frame_last,
                   input frame_seq, input trailer_sum, output ready);
endinterface

// ===== rtl/arqfr_rsp_if.sv =====
interface arqfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       reply_kind;
   logic [5:0] reply_seq;
   logic       reply_last;

   modport source (output valid, output reply_kind, output reply_seq,
                   output reply_last, input ready);
   modport sink   (input valid, input reply_kind, input reply_seq,
                   input reply_last, output ready);
endinterface

// ===== rtl/arqfr_ram.sv =====
module arqfr_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/arqfr_front.sv =====
module arqfr_front import arqfr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   arqfr_req_if.sink        req_port,
   input  queue_status_type queue_status,
   output cmd_push_type     push_out
);

   logic       in_frame_ff, in_frame_in;
   logic       escape_ff, escape_in;
   logic [7:0] xor_ff, xor_in;
   logic       take;

   // Bytes are taken whenever the queue can hold a possible end-of-frame command.
   assign req_port.ready = !queue_status.full;
   assign take = req_port.valid && !queue_status.full;

   // Flag removal, destuffing and the running checksum.
   always_comb begin
      in_frame_in = in_frame_ff;
      escape_in   = escape_ff;
      xor_in      = xor_ff;
      push_out.push     = 1'b0;
      push_out.cmd.seq  = req_port.frame_seq;
      push_out.cmd.good = ((xor_ff ^ req_port.trailer_sum) == 8'd0);
      if (take) begin
         if (req_port.frame_last) begin
            // The closing flag ends the frame and hands its verdict on.
            push_out.push = 1'b1;
            in_frame_in   = 1'b0;
            escape_in     = 1'b0;
            xor_in        = 8'd0;
         end else if (!in_frame_ff) begin
            in_frame_in = 1'b1;
         end else if ((req_port.data_byte == ESCAPE_BYTE) && !escape_ff) begin
            escape_in = 1'b1;
         end else begin
            xor_in    = xor_ff ^ req_port.data_byte;
            escape_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         escape_ff   <= 1'b0;
         xor_ff      <= 8'd0;
      end else begin
         in_frame_ff <= in_frame_in;
         escape_ff   <= escape_in;
         xor_ff      <= xor_in;
      end
   end

endmodule

// ===== rtl/arqfr_queue.sv =====
module arqfr_queue import arqfr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_push_type     push_in,
   input  logic             pop,
   output queue_status_type queue_status,
   output frame_cmd_type    head
);

   frame_cmd_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign queue_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign head = slot_ff[rd_ptr_ff];

   assign do_push = push_in.push && !queue_status.full;
   assign do_pop  = pop && !queue_status.empty;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command slots carry payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

endmodule

// ===== rtl/arqfr_back.sv =====
module arqfr_back import arqfr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type queue_status,
   input  frame_cmd_type    head,
   output logic             pop,
   arqfr_rsp_if.source      rsp_port
);

   back_state_type     state_ff, state_in;
   logic [EXP_W-1:0]   expected_ff, expected_in;
   logic [SEQ_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [SEQ_COUNT-1:0] valid_ff, valid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff;
   logic [5:0]         rsp_seq_ff;
   logic               rsp_last_ff;

   logic               emit;
   logic               emit_kind;
   logic [5:0]         emit_seq;
   logic               emit_last;

   logic               wr_en;
   logic               rd_en;
   logic [SEQ_W-1:0]   rd_addr;
   logic [1:0]         wr_data;
   logic [1:0]         rd_data;

   logic               slot_free;
   logic [1:0]         mark;
   logic               is_good;
   logic               is_bad;
   logic               at_end;
   logic               check_go;
   logic               head_in_range;
   logic [EXP_W-1:0]   head_exp;
   logic [SEQ_W-1:0]   head_idx;

   // Mark store; entries never written since reset read as unknown.
   arqfr_ram #(
      .WIDTH(2),
      .DEPTH(SEQ_COUNT)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free     = !rsp_valid_ff || rsp_port.ready;
   assign mark          = valid_ff[idx_ff] ? rd_data : MARK_UNKNOWN;
   assign is_good       = (mark == MARK_GOOD);
   assign is_bad        = (mark == MARK_BAD);
   assign at_end        = (idx_ff == SEQ_W'(SEQ_COUNT - 1));
   assign head_in_range = (32'(head.seq) < 32'(SEQ_COUNT));
   assign head_exp      = EXP_W'(head.seq);
   assign head_idx      = SEQ_W'(head.seq);
   assign wr_data       = head.good ? MARK_GOOD : MARK_BAD;

   // A walk step emits a transaction when an ACK is held back or the mark is bad.
   assign check_go = !(pend_ff || is_bad) || slot_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty && head_in_range) begin
               if (head_exp == expected_ff) begin
                  state_in = ST_READ;
               end else if (head_exp > expected_ff) begin
                  state_in = ST_AHEAD;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (check_go) begin
               if (is_good) begin
                  state_in = at_end ? ST_FLUSH : ST_CHECK;
               end else if (is_bad) begin
                  state_in = pend_ff ? ST_NACK : ST_IDLE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NACK, ST_FLUSH, ST_AHEAD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates per state.
   always_comb begin
      expected_in = expected_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      valid_in    = valid_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = idx_ff;
      emit        = 1'b0;
      emit_kind   = REPLY_ACK;
      emit_seq    = 6'(idx_ff);
      emit_last   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            pend_in = 1'b0;
            if (!queue_status.empty) begin
               pop    = 1'b1;
               idx_in = head_idx;
               if (head_in_range) begin
                  wr_en              = 1'b1;
                  valid_in[head_idx] = 1'b1;
               end
            end
         end
         ST_READ: begin
            rd_en = 1'b1;
         end
         ST_CHECK: begin
            if (check_go) begin
               if (pend_ff) begin
                  // Release the held ACK; it is last only if the walk stops silently.
                  emit      = 1'b1;
                  emit_kind = REPLY_ACK;
                  emit_seq  = 6'(idx_ff - SEQ_W'(1));
                  emit_last = !(is_good || is_bad);
               end else if (is_bad) begin
                  emit      = 1'b1;
                  emit_kind = REPLY_NACK;
               end
               if (is_good) begin
                  pend_in = 1'b1;
                  if (!at_end) begin
                     idx_in  = idx_ff + SEQ_W'(1);
                     rd_en   = 1'b1;
                     rd_addr = idx_ff + SEQ_W'(1);
                  end
               end else begin
                  pend_in     = 1'b0;
                  expected_in = EXP_W'(idx_ff);
               end
            end
         end
         ST_NACK: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_kind = REPLY_NACK;
            end
         end
         ST_FLUSH: begin
            // Every mark up to the top was good: the window runs off the end.
            if (slot_free) begin
               emit        = 1'b1;
               emit_kind   = REPLY_ACK;
               pend_in     = 1'b0;
               expected_in = EXP_W'(SEQ_COUNT);
            end
         end
         ST_AHEAD: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_kind = REPLY_NACK;
               emit_seq  = 6'(expected_ff);
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         expected_ff  <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_seq_ff  <= emit_seq;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.reply_kind = rsp_kind_ff;
   assign rsp_port.reply_seq  = rsp_seq_ff;
   assign rsp_port.reply_last = rsp_last_ff;

endmodule

// ===== rtl/arq_frame_receiver_core.sv =====
// Channel    Direction  Payload
// req_port   in         data_byte, frame_last, frame_seq, trailer_sum
// rsp_port   out        reply_kind, reply_seq, reply_last
//
// Bytes are taken whenever the four-entry command queue has room.
// A closing byte queues one command; the back end pops it and writes the mark, then a
// walk issues a read and visits marks in order, with a separate NACK step when a NACK
// follows ACKs or a flush step when it runs off the end; a frame ahead gets a NACK step.
// Reset clears the byte state, the queue, the expected number and the mark valid bits.
// A stalled reply holds the back end; the input stalls only once the queue is full.
module arq_frame_receiver_core import arqfr_pkg::*; (
   input logic         clock,
   input logic         reset,
   arqfr_req_if.sink   req_port,
   arqfr_rsp_if.source rsp_port
);

   cmd_push_type     push;
   queue_status_type queue_status;
   frame_cmd_type    head;
   logic             pop;

   // Byte front end: flags, destuffing and checksum.
   arqfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_port     (req_port),
      .queue_status (queue_status),
      .push_out     (push)
   );

   // End-of-frame commands waiting for the window logic.
   arqfr_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_in      (push),
      .pop          (pop),
      .queue_status (queue_status),
      .head         (head)
   );

   // Window back end: mark store, walk and replies.
   arqfr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head         (head),
      .pop          (pop),
      .rsp_port     (rsp_port)
   );

endmodule

// ===== rtl/arqfr_checker.sv =====
module arqfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       reply_kind,
   input logic [5:0] reply_seq,
   input logic       reply_last
);

   logic       walk_open_ff;
   logic [5:0] prev_seq_ff;

   // Track whether the previous accepted reply left a walk open.
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_open_ff <= 1'b0;
         prev_seq_ff  <= 6'd0;
      end else if (rsp_valid && rsp_ready) begin
         walk_open_ff <= !reply_last;
         prev_seq_ff  <= reply_seq;
      end
   end

   // A reply waiting to be taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("reply withdrawn before it was taken");

   // No reply is offered in the cycle after a reset cycle.
   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reply offered right after reset");

   // A negative acknowledgment always closes the frame's replies.
   a_nack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && reply_kind |-> reply_last)
      else $error("NACK not marked as last reply");

   // Within one walk, replies cover consecutive sequence numbers.
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && walk_open_ff |-> reply_seq == prev_seq_ff + 6'd1)
      else $error("walk reply out of order");

endmodule

bind arq_frame_receiver_core arqfr_checker u_arqfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .reply_kind (rsp_port.reply_kind),
   .reply_seq  (rsp_port.reply_seq),
   .reply_last (rsp_port.reply_last)
);
